@@ rtl/core/cfc_pkg.sv @@
// ----------------------------------------------------------------------------
// cfc_pkg
// shared types and constants of the crc frame checker
// ----------------------------------------------------------------------------
package cfc_pkg;

    localparam int CFC_MAX_WIDTH = 16;

    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CRC_WIDTH_BITS = 5;
    localparam int POLY_BITS      = 16;
    localparam int FLEN_BITS      = 15;
    localparam int TDATA_BITS     = 8;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CRC_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLYNOMIAL   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_LENGTH = 2'd2;

    // reset values
    localparam logic [CRC_WIDTH_BITS-1:0] RST_CRC_WIDTH    = 5'd16;
    localparam logic [POLY_BITS-1:0]      RST_POLYNOMIAL   = 16'd0;
    localparam logic [FLEN_BITS-1:0]      RST_FRAME_LENGTH = 15'd16;

    // frame position flags for the current request
    typedef struct packed {
        logic invert;
        logic last;
    } t_frame_ctl;

    // common controls broadcast to every cell
    typedef struct packed {
        logic en;
        logic restart;
        logic fb;
    } t_cell_ctl;

endpackage

@@ rtl/core/cfc_cell.sv @@
// ----------------------------------------------------------------------------
// cfc_cell
// one bit of the crc shift register
// ----------------------------------------------------------------------------
module cfc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfc_pkg::t_cell_ctl i_ctl,
    input  logic              i_prev,
    input  logic              i_tap,
    output logic              o_q,
    output logic              o_next
);
    import cfc_pkg::*;

    logic r_q;

    // low cell takes the feedback, others the neighbor plus tap
    assign o_next = i_prev ^ (i_ctl.fb & i_tap);
    assign o_q    = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= 1'b1;
        end else if (i_ctl.en) begin
            r_q <= i_ctl.restart ? 1'b1 : o_next;
        end
    end

endmodule

@@ rtl/core/cfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfc_ctrl
// configuration registers, frame bit counter and width decode
// ----------------------------------------------------------------------------
module cfc_ctrl #(
    parameter int MAX_WIDTH = cfc_pkg::CFC_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cfc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [cfc_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                               i_step,
    output cfc_pkg::t_frame_ctl                o_frame,
    output logic [MAX_WIDTH-1:0]               o_wmask,
    output logic [MAX_WIDTH-1:0]               o_top_sel,
    output logic [cfc_pkg::POLY_BITS-1:0]      o_poly
);
    import cfc_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [CRC_WIDTH_BITS-1:0] r_crc_width;
    logic [POLY_BITS-1:0]      r_poly;
    logic [FLEN_BITS-1:0]      r_flen;
    logic [FLEN_BITS-1:0]      r_bit_count;
    logic [FLEN_BITS-1:0]      n_bit_count;

    logic [5:0]           cw6;
    logic [WW-1:0]        eff_w;
    logic [FLEN_BITS-1:0] len;
    logic [FLEN_BITS-1:0] remain;
    logic [FLEN_BITS:0]   count_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_width <= RST_CRC_WIDTH;
            r_poly      <= RST_POLYNOMIAL;
            r_flen      <= RST_FRAME_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CRC_WIDTH:    r_crc_width <= i_cfg_wdata[CRC_WIDTH_BITS-1:0];
                CFG_POLYNOMIAL:   r_poly      <= i_cfg_wdata[POLY_BITS-1:0];
                CFG_FRAME_LENGTH: r_flen      <= i_cfg_wdata[FLEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // width saturated into 1..MAX_WIDTH
    always_comb begin
        cw6 = {1'b0, r_crc_width};
        if (cw6 == 6'd0) begin
            eff_w = WW'(1);
        end else if (cw6 > 6'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(cw6);
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_WIDTH; k++) begin
            o_wmask[k]   = (WW'(k) < eff_w);
            o_top_sel[k] = (WW'(k) == (eff_w - WW'(1)));
        end
    end

    // zero frame length behaves as one
    assign len       = (r_flen == '0) ? FLEN_BITS'(1) : r_flen;
    assign remain    = len - r_bit_count;
    assign count_inc = {1'b0, r_bit_count} + (FLEN_BITS+1)'(1);

    assign o_frame.last   = (count_inc >= {1'b0, len});
    assign o_frame.invert = (r_bit_count >= len) || (remain <= FLEN_BITS'(eff_w));
    assign o_poly         = r_poly;

    assign n_bit_count = o_frame.last ? '0 : count_inc[FLEN_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= '0;
        end else if (i_step) begin
            r_bit_count <= n_bit_count;
        end
    end

endmodule

@@ rtl/core/crc_frame_checker_top.sv @@
// ----------------------------------------------------------------------------
// crc_frame_checker_top
// bit-serial crc checker for frames ending in a complemented crc
// result: the verdict is registered and appears in the cycle after the last bit is taken
// throughput: one bit per cycle while no verdict is stuck, set by the single-step shift through the cells
// a pending result holds the output register; input keeps flowing if taken
// reset: synchronous active low, register all ones, counter zero, config to
// defaults (width 16, polynomial 0, frame length 16)
// ----------------------------------------------------------------------------
module crc_frame_checker_top #(
    parameter int MAX_WIDTH = cfc_pkg::CFC_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [cfc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [cfc_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // bit stream in
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [cfc_pkg::TDATA_BITS-1:0]     i_s_tdata,   // [0] data_bit
    // frame verdict out
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [cfc_pkg::TDATA_BITS-1:0]     o_m_tdata    // [0] crc_ok
);
    import cfc_pkg::*;

    t_frame_ctl          frame;
    t_cell_ctl           cell_ctl;
    logic [MAX_WIDTH-1:0] wmask;
    logic [MAX_WIDTH-1:0] top_sel;
    logic [MAX_WIDTH-1:0] taps;
    logic [MAX_WIDTH-1:0] q;
    logic [MAX_WIDTH-1:0] q_next;
    logic [MAX_WIDTH-1:0] prev;
    logic [POLY_BITS-1:0] poly;

    logic s_accept;
    logic rx_bit;
    logic top_bit;
    logic ok;

    logic r_m_valid;
    logic n_m_valid;
    logic r_ok;

    // a new bit is taken unless a verdict is stuck in the output register
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    cfc_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (s_accept),
        .o_frame     (frame),
        .o_wmask     (wmask),
        .o_top_sel   (top_sel),
        .o_poly      (poly)
    );

    // trailing crc bits arrive complemented
    assign rx_bit  = i_s_tdata[0] ^ frame.invert;
    // top of the active register, picked by the decoded width
    assign top_bit = |(q & top_sel);

    assign cell_ctl.en      = s_accept;
    assign cell_ctl.restart = frame.last;
    assign cell_ctl.fb      = top_bit ^ rx_bit;

    // chain of cells: cell k takes cell k-1, the low cell takes the feedback
    genvar k;
    generate
        for (k = 0; k < MAX_WIDTH; k++) begin : g_cell
            if (k == 0) begin : g_low
                assign prev[k] = 1'b0;
                assign taps[k] = 1'b1;
            end else begin : g_up
                assign prev[k] = q[k-1];
                if (k < POLY_BITS) begin : g_tap
                    assign taps[k] = poly[k] & wmask[k];
                end else begin : g_notap
                    assign taps[k] = 1'b0;
                end
            end

            cfc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl),
                .i_prev  (prev[k]),
                .i_tap   (taps[k]),
                .o_q     (q[k]),
                .o_next  (q_next[k])
            );
        end
    endgenerate

    // frame passes when the updated active register is all zero
    assign ok = ((q_next & wmask) == '0);

    // output register, loaded on the last bit of each frame
    always_comb begin
        if (s_accept && frame.last) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && frame.last) begin
            r_ok <= ok;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(TDATA_BITS-1){1'b0}}, r_ok};

endmodule

@@ rtl/core/cfc_checker.sv @@
// ----------------------------------------------------------------------------
// cfc_checker
// port-level checks of the crc frame checker
// ----------------------------------------------------------------------------
module cfc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic [cfc_pkg::TDATA_BITS-1:0]     i_s_tdata,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [cfc_pkg::TDATA_BITS-1:0]     o_m_tdata
);
    import cfc_pkg::*;

    // stalled verdict holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled verdict changed");

    // input stalls only behind a stuck verdict
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without a pending verdict");

    // a taken verdict with no new bit leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !(i_s_tvalid && o_s_tready) |=> !o_m_tvalid)
        else $error("verdict repeated");

    // verdict appears only after a bit is taken
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid && !(i_s_tvalid && o_s_tready) |=> !o_m_tvalid)
        else $error("verdict without input");

    // pad bits of the verdict stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[TDATA_BITS-1:1] == '0)
        else $error("verdict pad bits set");

endmodule

bind crc_frame_checker_top cfc_checker u_cfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
